[hw/rtl/sgtd_pkg.sv]
package sgtd_pkg;

   localparam int MAX_SPAN_DEF = 1024;
   localparam int MAX_RESULTS  = 44;

   localparam int IDX_W      = 11;
   localparam int POS_W      = 17;
   localparam int LOW_W      = 16;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CNT_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CMD_W-1:0] CMD_VISIT     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND_LEAF = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND_NODE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADCFG = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_VISIT,
      S_FIND,
      S_CLOSE
   } sgtd_state_type;

   typedef enum logic [1:0] {
      PH_ENTER,
      PH_LEFT,
      PH_RIGHT
   } sgtd_phase_type;

   typedef struct packed {
      logic [IDX_W-1:0]    index;
      logic [POS_W-1:0]    low;
      logic [POS_W-1:0]    high;
      logic                full;
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
   } sgtd_rec_type;

   typedef struct packed {
      logic         push;
      logic         close;
      sgtd_rec_type rec;
   } sgtd_rsp_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] low;
      logic [POS_W-1:0] high;
      logic [CNT_W-1:0] count;
      logic             bad;
   } sgtd_cfg_type;

endpackage

[hw/rtl/sgtd_csr.sv]
module sgtd_csr #(
   parameter int MAX_SPAN = sgtd_pkg::MAX_SPAN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sgtd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sgtd_pkg::sgtd_cfg_type              cfg
);

   localparam int POS_W = sgtd_pkg::POS_W;
   localparam int LOW_W = sgtd_pkg::LOW_W;
   localparam int CNT_W = sgtd_pkg::CNT_W;

   logic [LOW_W-1:0] range_low_ff, range_low_in;
   logic [POS_W-1:0] range_high_ff, range_high_in;
   logic [POS_W-1:0] span;

   assign csr_ready = 1'b1;

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_valid) begin
         case (csr_index)
            sgtd_pkg::REG_RANGE_LOW:  range_low_in  = csr_wdata[LOW_W-1:0];
            sgtd_pkg::REG_RANGE_HIGH: range_high_in = csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= POS_W'(1024);
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   assign span      = range_high_ff - {1'b0, range_low_ff};
   assign cfg.low   = {1'b0, range_low_ff};
   assign cfg.high  = range_high_ff;
   assign cfg.bad   = ({1'b0, range_low_ff} >= range_high_ff) || (span > POS_W'(MAX_SPAN));
   assign cfg.count = {span[CNT_W-2:0], 1'b0} - CNT_W'(1);

endmodule

[hw/rtl/sgtd_rsp.sv]
module sgtd_rsp (
   input  logic                      clock,
   input  logic                      reset,
   input  sgtd_pkg::sgtd_rsp_cmd_type cmd,
   output logic                      rsp_valid,
   output logic                      rsp_last,
   output sgtd_pkg::sgtd_rec_type    rsp_rec
);

   logic                   pend_valid_ff, pend_valid_in;
   sgtd_pkg::sgtd_rec_type pend_ff, pend_in;
   logic                   valid_ff, valid_in;
   logic                   last_ff, last_in;
   sgtd_pkg::sgtd_rec_type rec_ff, rec_in;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      valid_in      = 1'b0;
      last_in       = 1'b0;
      rec_in        = rec_ff;
      if (cmd.push) begin
         valid_in      = pend_valid_ff;
         rec_in        = pend_ff;
         pend_in       = cmd.rec;
         pend_valid_in = 1'b1;
      end else if (cmd.close) begin
         valid_in      = 1'b1;
         last_in       = 1'b1;
         rec_in        = pend_valid_ff ? pend_ff : cmd.rec;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      last_ff <= last_in;
      rec_ff  <= rec_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_last  = last_ff;
   assign rsp_rec   = rec_ff;

endmodule

[hw/rtl/sgtd_seq.sv]
module sgtd_seq #(
   parameter int MAX_SPAN = sgtd_pkg::MAX_SPAN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sgtd_pkg::CMD_W-1:0]       req_command,
   input  logic [sgtd_pkg::POS_W-1:0]       req_query_low,
   input  logic [sgtd_pkg::POS_W-1:0]       req_query_high,
   input  sgtd_pkg::sgtd_cfg_type           cfg,
   output sgtd_pkg::sgtd_rsp_cmd_type       rsp_cmd
);

   localparam int POS_W = sgtd_pkg::POS_W;
   localparam int IDX_W = sgtd_pkg::IDX_W;
   localparam int CMD_W = sgtd_pkg::CMD_W;
   localparam int DEPTH = $clog2(MAX_SPAN) + 1;
   localparam int D_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int N_W   = $clog2(sgtd_pkg::MAX_RESULTS + 1);

   sgtd_pkg::sgtd_state_type state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [POS_W-1:0]         qb_ff, qb_in;
   logic [POS_W-1:0]         qe_ff, qe_in;
   logic [D_W-1:0]           d_ff, d_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [N_W-1:0]           n_ff, n_in;
   logic [POS_W-1:0]         lo_stk_ff [DEPTH];
   logic [POS_W-1:0]         lo_stk_in [DEPTH];
   logic [POS_W-1:0]         hi_stk_ff [DEPTH];
   logic [POS_W-1:0]         hi_stk_in [DEPTH];
   sgtd_pkg::sgtd_phase_type ph_stk_ff [DEPTH];
   sgtd_pkg::sgtd_phase_type ph_stk_in [DEPTH];
   sgtd_pkg::sgtd_rec_type   close_rec_ff, close_rec_in;

   logic [POS_W-1:0] cur_lo, cur_hi, mid, span_m;
   logic [POS_W:0]   sum;
   logic [D_W-1:0]   d_nxt;
   logic             is_leaf, covered;
   logic             do_pop, do_emit, full_v;

   assign cur_lo  = lo_stk_ff[d_ff];
   assign cur_hi  = hi_stk_ff[d_ff];
   assign sum     = {1'b0, cur_lo} + {1'b0, cur_hi};
   assign mid     = sum[POS_W:1];
   assign span_m  = cur_hi - cur_lo;
   assign is_leaf = span_m <= POS_W'(1);
   assign covered = (qb_ff <= cur_lo) && (cur_hi <= qe_ff);
   assign d_nxt   = d_ff + D_W'(1);
   assign busy    = state_ff != sgtd_pkg::S_IDLE;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      qb_in        = qb_ff;
      qe_in        = qe_ff;
      d_in         = d_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      lo_stk_in    = lo_stk_ff;
      hi_stk_in    = hi_stk_ff;
      ph_stk_in    = ph_stk_ff;
      close_rec_in = close_rec_ff;
      rsp_cmd      = '0;
      do_pop       = 1'b0;
      do_emit      = 1'b0;
      full_v       = 1'b0;
      case (state_ff)
         sgtd_pkg::S_IDLE: begin
            if (start) begin
               cmd_in       = req_command;
               qb_in        = req_query_low;
               qe_in        = req_query_high;
               d_in         = '0;
               idx_in       = IDX_W'(1);
               n_in         = '0;
               lo_stk_in[0] = cfg.low;
               hi_stk_in[0] = cfg.high;
               ph_stk_in[0] = sgtd_pkg::PH_ENTER;
               close_rec_in = '0;
               close_rec_in.status = sgtd_pkg::ST_OK;
               close_rec_in.count  = cfg.count;
               if (cfg.bad) begin
                  close_rec_in.status = sgtd_pkg::ST_BADCFG;
                  close_rec_in.count  = '0;
                  state_in = sgtd_pkg::S_CLOSE;
               end else if (req_command == sgtd_pkg::CMD_VISIT) begin
                  if (req_query_low >= req_query_high) begin
                     close_rec_in.status = sgtd_pkg::ST_EMPTY;
                     state_in = sgtd_pkg::S_CLOSE;
                  end else begin
                     state_in = sgtd_pkg::S_VISIT;
                  end
               end else if (req_command == sgtd_pkg::CMD_FIND_LEAF ||
                            req_command == sgtd_pkg::CMD_FIND_NODE) begin
                  state_in = sgtd_pkg::S_FIND;
               end else begin
                  state_in = sgtd_pkg::S_CLOSE;
               end
            end
         end
         sgtd_pkg::S_FIND: begin
            if (cmd_ff == sgtd_pkg::CMD_FIND_NODE && qb_ff == cur_lo && qe_ff == cur_hi) begin
               close_rec_in.index = idx_ff;
               close_rec_in.low   = cur_lo;
               close_rec_in.high  = cur_hi;
               close_rec_in.found = 1'b1;
               state_in = sgtd_pkg::S_CLOSE;
            end else if (is_leaf) begin
               if (cmd_ff == sgtd_pkg::CMD_FIND_LEAF && qb_ff == cur_lo) begin
                  close_rec_in.index = idx_ff;
                  close_rec_in.low   = cur_lo;
                  close_rec_in.high  = cur_hi;
                  close_rec_in.found = 1'b1;
               end
               state_in = sgtd_pkg::S_CLOSE;
            end else if (qb_ff < mid) begin
               hi_stk_in[d_ff] = mid;
               idx_in = {idx_ff[IDX_W-2:0], 1'b0};
            end else begin
               lo_stk_in[d_ff] = mid;
               idx_in = {idx_ff[IDX_W-2:0], 1'b1};
            end
         end
         sgtd_pkg::S_VISIT: begin
            case (ph_stk_ff[d_ff])
               sgtd_pkg::PH_ENTER: begin
                  if (covered) begin
                     do_emit = 1'b1;
                     full_v  = 1'b1;
                     do_pop  = 1'b1;
                  end else if (is_leaf) begin
                     do_pop = 1'b1;
                  end else begin
                     ph_stk_in[d_ff] = sgtd_pkg::PH_LEFT;
                     if (qb_ff < mid) begin
                        lo_stk_in[d_nxt] = cur_lo;
                        hi_stk_in[d_nxt] = mid;
                        ph_stk_in[d_nxt] = sgtd_pkg::PH_ENTER;
                        idx_in = {idx_ff[IDX_W-2:0], 1'b0};
                        d_in   = d_nxt;
                     end
                  end
               end
               sgtd_pkg::PH_LEFT: begin
                  ph_stk_in[d_ff] = sgtd_pkg::PH_RIGHT;
                  if (mid < qe_ff) begin
                     lo_stk_in[d_nxt] = mid;
                     hi_stk_in[d_nxt] = cur_hi;
                     ph_stk_in[d_nxt] = sgtd_pkg::PH_ENTER;
                     idx_in = {idx_ff[IDX_W-2:0], 1'b1};
                     d_in   = d_nxt;
                  end
               end
               sgtd_pkg::PH_RIGHT: begin
                  do_emit = 1'b1;
                  do_pop  = 1'b1;
               end
               default: begin
                  do_pop = 1'b1;
               end
            endcase
            if (do_emit) begin
               rsp_cmd.push       = 1'b1;
               rsp_cmd.rec.index  = idx_ff;
               rsp_cmd.rec.low    = cur_lo;
               rsp_cmd.rec.high   = cur_hi;
               rsp_cmd.rec.full   = full_v;
               rsp_cmd.rec.found  = 1'b1;
               rsp_cmd.rec.status = sgtd_pkg::ST_OK;
               rsp_cmd.rec.count  = close_rec_ff.count;
               n_in = n_ff + N_W'(1);
            end
            if (do_emit && n_ff == N_W'(sgtd_pkg::MAX_RESULTS - 1)) begin
               state_in = sgtd_pkg::S_CLOSE;
            end else if (do_pop) begin
               if (d_ff == '0) begin
                  state_in = sgtd_pkg::S_CLOSE;
               end else begin
                  d_in   = d_ff - D_W'(1);
                  idx_in = idx_ff >> 1;
               end
            end
         end
         sgtd_pkg::S_CLOSE: begin
            rsp_cmd.close = 1'b1;
            rsp_cmd.rec   = close_rec_ff;
            state_in      = sgtd_pkg::S_IDLE;
         end
         default: begin
            state_in = sgtd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgtd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      qb_ff        <= qb_in;
      qe_ff        <= qe_in;
      d_ff         <= d_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      lo_stk_ff    <= lo_stk_in;
      hi_stk_ff    <= hi_stk_in;
      ph_stk_ff    <= ph_stk_in;
      close_rec_ff <= close_rec_in;
   end

endmodule

[hw/rtl/segment_tree_range_decomposer.sv]
// Segment tree range decomposer over the configured range [range_low, range_high).
// A command is taken when start is high and busy is low; busy then stays high until
// its last word has been issued. Words appear on the rsp_ ports for one cycle each,
// marked by rsp_valid, and must be taken then: the receiver cannot stall the block.
// One shared midpoint adder and a set of comparators advance the tree walk by one step a cycle.
// find_leaf and find_node descend one tree level per step, through up to log2(span)+1
// levels. A visit takes each partially covered inner node through its enter, left and
// right phases and each covered node or uncovered leaf through the enter phase only.
// Errors and unused commands issue only a final word. Up to 44 nodes are reported
// per visit; the final word of every command carries rsp_last.
module segment_tree_range_decomposer #(
   parameter int MAX_SPAN = sgtd_pkg::MAX_SPAN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sgtd_pkg::CMD_W-1:0]        req_command,
   input  logic [sgtd_pkg::POS_W-1:0]        req_query_low,
   input  logic [sgtd_pkg::POS_W-1:0]        req_query_high,
   output logic                              rsp_valid,
   output logic [sgtd_pkg::IDX_W-1:0]        rsp_node_index,
   output logic [sgtd_pkg::POS_W-1:0]        rsp_node_low,
   output logic [sgtd_pkg::POS_W-1:0]        rsp_node_high,
   output logic                              rsp_fully_inside,
   output logic                              rsp_found,
   output logic [sgtd_pkg::STATUS_W-1:0]     rsp_status,
   output logic [sgtd_pkg::CNT_W-1:0]        rsp_node_count,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sgtd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgtd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sgtd_pkg::sgtd_cfg_type     cfg;
   sgtd_pkg::sgtd_rsp_cmd_type rsp_cmd;
   sgtd_pkg::sgtd_rec_type     rsp_rec;

   sgtd_csr #(
      .MAX_SPAN (MAX_SPAN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sgtd_seq #(
      .MAX_SPAN (MAX_SPAN)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_query_low  (req_query_low),
      .req_query_high (req_query_high),
      .cfg            (cfg),
      .rsp_cmd        (rsp_cmd)
   );

   sgtd_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rsp_cmd),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_node_index   = rsp_rec.index;
   assign rsp_node_low     = rsp_rec.low;
   assign rsp_node_high    = rsp_rec.high;
   assign rsp_fully_inside = rsp_rec.full;
   assign rsp_found        = rsp_rec.found;
   assign rsp_status       = rsp_rec.status;
   assign rsp_node_count   = rsp_rec.count;

endmodule

[hw/rtl/sgtd_chk.sv]
module sgtd_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [sgtd_pkg::IDX_W-1:0]        rsp_node_index,
   input logic [sgtd_pkg::POS_W-1:0]        rsp_node_low,
   input logic [sgtd_pkg::POS_W-1:0]        rsp_node_high,
   input logic                              rsp_fully_inside,
   input logic                              rsp_found,
   input logic [sgtd_pkg::STATUS_W-1:0]     rsp_status,
   input logic [sgtd_pkg::CNT_W-1:0]        rsp_node_count,
   input logic                              rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_node_index == '0 && rsp_node_low == '0 &&
                                  rsp_node_high == '0 && !rsp_fully_inside)
      else $error("word without node carries node fields");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sgtd_pkg::ST_OK |-> rsp_last && !rsp_found)
      else $error("error word is not a lone final word");

   a_badcfg_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sgtd_pkg::ST_BADCFG |-> rsp_node_count == '0)
      else $error("bad configuration word reports a node count");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("word follows final word without a gap");

endmodule

bind segment_tree_range_decomposer sgtd_chk u_chk (.*);
